[sv/cgl_pkg.sv]
// Shared types and constants for the cmap glyph lookup block.
package cgl_pkg;
  localparam int MAX_GROUPS_DEF = 256;
  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int ARRAY_WORDS_DEF = 4096;
  localparam logic [20:0] BMP_LAST = 21'h00FFFF;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_GROUP = 2'd1;
  localparam logic [1:0] OP_SEGMENT = 2'd2;
  localparam logic [1:0] OP_WORD = 2'd3;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_GROUP = 2'd1;
  localparam logic [1:0] SRC_DELTA = 2'd2;
  localparam logic [1:0] SRC_ARRAY = 2'd3;

  localparam logic [1:0] REG_GROUPS = 2'd0;
  localparam logic [1:0] REG_SEGMENTS = 2'd1;
  localparam logic [1:0] REG_WORDS = 2'd2;

  typedef struct packed {
    logic load;      // capture input beat
    logic write;     // perform store write
    logic grp_rd;    // issue group read at scan index
    logic seg_rd;    // issue segment read at scan index
    logic word_rd;   // issue word read
    logic scan_clr;  // reset scan index
    logic scan_inc;  // advance scan index
  } cgl_cmd_t;

  typedef struct packed {
    logic grp_hit;
    logic grp_done;   // scan index reached group count
    logic bmp;        // code at or below 0xFFFF
    logic seg_skip;   // segment last below code
    logic seg_miss;   // code below segment first
    logic seg_done;
    logic seg_delta;  // zero offset
    logic word_oob;
  } cgl_sts_t;
endpackage

[sv/cgl_datapath.sv]
// Datapath: table memories, scan index and result computation.
module cgl_datapath #(
  parameter int MAX_GROUPS = cgl_pkg::MAX_GROUPS_DEF,
  parameter int MAX_SEGMENTS = cgl_pkg::MAX_SEGMENTS_DEF,
  parameter int ARRAY_WORDS = cgl_pkg::ARRAY_WORDS_DEF
) (
  input  logic              clk,
  input  cgl_pkg::cgl_cmd_t cmd,
  output cgl_pkg::cgl_sts_t sts,
  input  logic [1:0]        opcode,
  input  logic [11:0]       entry_index,
  input  logic [20:0]       code_point,
  input  logic [31:0]       range_start,
  input  logic [31:0]       range_end,
  input  logic [31:0]       glyph_base,
  input  logic [15:0]       seg_delta,
  input  logic [15:0]       seg_range_offset,
  input  logic [15:0]       word_value,
  input  logic [8:0]        group_count,
  input  logic [8:0]        segment_count,
  input  logic [12:0]       array_word_count,
  output logic [31:0]       grp_glyph_id,
  output logic [15:0]       seg_glyph_id,
  output logic              word_zero
);
  import cgl_pkg::*;
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int AW = (ARRAY_WORDS > 1) ? $clog2(ARRAY_WORDS) : 1;
  localparam int IW = (GW > SW ? GW : SW) + 1;

  logic [31:0] grp_first_mem [MAX_GROUPS];
  logic [31:0] grp_last_mem [MAX_GROUPS];
  logic [31:0] grp_glyph_mem [MAX_GROUPS];
  logic [15:0] seg_first_mem [MAX_SEGMENTS];
  logic [15:0] seg_last_mem [MAX_SEGMENTS];
  logic [15:0] seg_delta_mem [MAX_SEGMENTS];
  logic [15:0] seg_off_mem [MAX_SEGMENTS];
  logic [15:0] word_mem [ARRAY_WORDS];

  logic [1:0]  op;
  logic [11:0] idx;
  logic [20:0] code;
  logic [31:0] start, last, base;
  logic [15:0] delta, roff, wval;
  logic [IW-1:0] scan;
  logic [31:0] g_first, g_last, g_glyph;
  logic [15:0] s_first, s_last, s_delta, s_off, word;
  logic [IW-1:0] seg_at;
  logic [17:0] word_idx;
  logic [16:0] gmax, smax;
  logic [16:0] amax;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode;
      idx <= entry_index;
      code <= code_point;
      start <= range_start;
      last <= range_end;
      base <= glyph_base;
      delta <= seg_delta;
      roff <= seg_range_offset;
      wval <= word_value;
    end
    if (cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && op == OP_GROUP && 32'(idx) < 32'(MAX_GROUPS)) begin
      grp_first_mem[idx[GW-1:0]] <= start;
      grp_last_mem[idx[GW-1:0]] <= last;
      grp_glyph_mem[idx[GW-1:0]] <= base;
    end
    if (cmd.grp_rd) begin
      g_first <= grp_first_mem[scan[GW-1:0]];
      g_last <= grp_last_mem[scan[GW-1:0]];
      g_glyph <= grp_glyph_mem[scan[GW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && op == OP_SEGMENT && 32'(idx) < 32'(MAX_SEGMENTS)) begin
      seg_first_mem[idx[SW-1:0]] <= start[15:0];
      seg_last_mem[idx[SW-1:0]] <= last[15:0];
      seg_delta_mem[idx[SW-1:0]] <= delta;
      seg_off_mem[idx[SW-1:0]] <= roff;
    end
    if (cmd.seg_rd) begin
      s_first <= seg_first_mem[scan[SW-1:0]];
      s_last <= seg_last_mem[scan[SW-1:0]];
      s_delta <= seg_delta_mem[scan[SW-1:0]];
      s_off <= seg_off_mem[scan[SW-1:0]];
      seg_at <= scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && op == OP_WORD && 32'(idx) < 32'(ARRAY_WORDS)) begin
      word_mem[idx[AW-1:0]] <= wval;
    end
    if (cmd.word_rd) begin
      word <= word_mem[word_idx[AW-1:0]];
    end
  end

  always_comb begin
    gmax = (32'(group_count) > 32'(MAX_GROUPS)) ? 17'(MAX_GROUPS) : 17'(group_count);
    smax = (32'(segment_count) > 32'(MAX_SEGMENTS)) ? 17'(MAX_SEGMENTS)
                                                    : 17'(segment_count);
    amax = (32'(array_word_count) > 32'(ARRAY_WORDS)) ? 17'(ARRAY_WORDS)
                                                      : 17'(array_word_count);
    word_idx = 18'(seg_at) + 18'(s_off[15:1]) + 18'(code[15:0] - s_first);
    sts.grp_hit = (32'(code) >= g_first) && (32'(code) <= g_last);
    sts.grp_done = 17'(scan) >= gmax;
    sts.seg_done = 17'(scan) >= smax;
    sts.bmp = code <= BMP_LAST;
    sts.seg_skip = code[15:0] > s_last;
    sts.seg_miss = code[15:0] < s_first;
    sts.seg_delta = s_off == 16'd0;
    sts.word_oob = word_idx >= 18'(amax);
    grp_glyph_id = g_glyph + (32'(code) - g_first);
    seg_glyph_id = sts.seg_delta ? (code[15:0] + s_delta) : (word + s_delta);
    word_zero = word == 16'd0;
  end
endmodule

[sv/cgl_control.sv]
// Controller: sequences load, table write, group scan, segment scan, word read and output register.
module cgl_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  output logic              out_valid,
  input  logic              out_ready,
  output cgl_pkg::cgl_cmd_t cmd,
  input  cgl_pkg::cgl_sts_t sts,
  input  logic [31:0]       grp_glyph_id,
  input  logic [15:0]       seg_glyph_id,
  input  logic              word_zero,
  output logic [31:0]       glyph_id,
  output logic [1:0]        map_source
);
  import cgl_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC = 3'd1;
  localparam logic [2:0] S_GRD = 3'd2;
  localparam logic [2:0] S_GCHK = 3'd3;
  localparam logic [2:0] S_SRD = 3'd4;
  localparam logic [2:0] S_SCHK = 3'd5;
  localparam logic [2:0] S_WCHK = 3'd6;

  logic [2:0] state, state_next;
  logic       fin;
  logic [31:0] res_glyph;
  logic [1:0]  res_src;
  logic [1:0]  op;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    fin = 1'b0;
    res_glyph = 32'd0;
    res_src = SRC_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid && in_ready;
        if (in_valid && in_ready) state_next = S_DEC;
      end
      S_DEC: begin
        cmd.scan_clr = 1'b1;
        if (op == OP_LOOKUP) begin
          state_next = S_GRD;
        end else begin
          cmd.write = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_GRD: begin
        if (sts.grp_done) begin
          cmd.scan_clr = 1'b1;
          if (sts.bmp) begin
            state_next = S_SRD;
          end else begin
            fin = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.grp_rd = 1'b1;
          cmd.scan_inc = 1'b1;
          state_next = S_GCHK;
        end
      end
      S_GCHK: begin
        if (sts.grp_hit) begin
          fin = 1'b1;
          res_glyph = grp_glyph_id;
          res_src = SRC_GROUP;
          state_next = S_IDLE;
        end else begin
          state_next = S_GRD;
        end
      end
      S_SRD: begin
        if (sts.seg_done) begin
          fin = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.seg_rd = 1'b1;
          cmd.scan_inc = 1'b1;
          state_next = S_SCHK;
        end
      end
      S_SCHK: begin
        if (sts.seg_skip) begin
          state_next = S_SRD;
        end else if (sts.seg_miss) begin
          fin = 1'b1;
          state_next = S_IDLE;
        end else if (sts.seg_delta) begin
          fin = 1'b1;
          res_glyph = {16'd0, seg_glyph_id};
          res_src = SRC_DELTA;
          state_next = S_IDLE;
        end else if (sts.word_oob) begin
          fin = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.word_rd = 1'b1;
          state_next = S_WCHK;
        end
      end
      S_WCHK: begin
        fin = 1'b1;
        if (!word_zero) begin
          res_glyph = {16'd0, seg_glyph_id};
          res_src = SRC_ARRAY;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) op <= opcode;
    if (fin) begin
      glyph_id <= res_glyph;
      map_source <= res_src;
    end
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

[sv/cmap_glyph_lookup.sv]
// Top level: cmap format-12/format-4 glyph lookup with stream ports.
// A write passes through accept and decode; a lookup scans the groups, reading then checking
// each entry, and on a group miss, for a code at or below 0xFFFF, scans the segments, with a
// word read where the segment has a nonzero range offset and the word index is in range.
// One item at a time: a new beat is accepted only in idle with no result pending.
// Reset: synchronous, clears control state and counts; tables undefined until written.
module cmap_glyph_lookup #(
  parameter int MAX_GROUPS = cgl_pkg::MAX_GROUPS_DEF,
  parameter int MAX_SEGMENTS = cgl_pkg::MAX_SEGMENTS_DEF,
  parameter int ARRAY_WORDS = cgl_pkg::ARRAY_WORDS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode, entry_index, code_point, range_start, range_end, glyph_base,
  // seg_delta, seg_range_offset, word_value, zero pad
  input  logic [183:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // glyph_id, map_source, zero pad
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data
);
  import cgl_pkg::*;

  cgl_cmd_t cmd;
  cgl_sts_t sts;
  logic [8:0]  group_count, segment_count;
  logic [12:0] array_word_count;
  logic [31:0] grp_glyph_id, glyph_id;
  logic [15:0] seg_glyph_id;
  logic        word_zero;
  logic [1:0]  map_source;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= '0;
      segment_count <= '0;
      array_word_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GROUPS: group_count <= cfg_data[8:0];
        REG_SEGMENTS: segment_count <= cfg_data[8:0];
        REG_WORDS: array_word_count <= cfg_data;
        default: ;
      endcase
    end
  end

  cgl_control u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .opcode(s_axis_tdata[1:0]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd, .sts, .grp_glyph_id, .seg_glyph_id, .word_zero,
    .glyph_id, .map_source
  );

  cgl_datapath #(
    .MAX_GROUPS(MAX_GROUPS), .MAX_SEGMENTS(MAX_SEGMENTS), .ARRAY_WORDS(ARRAY_WORDS)
  ) u_dp (
    .clk, .cmd, .sts,
    .opcode(s_axis_tdata[1:0]),
    .entry_index(s_axis_tdata[13:2]),
    .code_point(s_axis_tdata[34:14]),
    .range_start(s_axis_tdata[66:35]),
    .range_end(s_axis_tdata[98:67]),
    .glyph_base(s_axis_tdata[130:99]),
    .seg_delta(s_axis_tdata[146:131]),
    .seg_range_offset(s_axis_tdata[162:147]),
    .word_value(s_axis_tdata[178:163]),
    .group_count, .segment_count, .array_word_count,
    .grp_glyph_id, .seg_glyph_id, .word_zero
  );

  assign m_axis_tdata = {6'd0, map_source, glyph_id};
endmodule

[sv/cgl_checker.sv]
// Port-level checker for the glyph lookup, bound to the top level.
module cgl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import cgl_pkg::*;
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready held after accept");
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[33:32] == SRC_NONE |-> m_axis_tdata[31:0] == 32'd0)
    else $error("unmapped result with nonzero glyph");
  a_seg_narrow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[33:32] == SRC_DELTA || m_axis_tdata[33:32] == SRC_ARRAY)
    |-> m_axis_tdata[31:16] == 16'd0)
    else $error("segment glyph above 16 bits");
endmodule

bind cmap_glyph_lookup cgl_checker u_cgl_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

[verif/cmap_glyph_lookup_tb.sv]
// Testbench for cmap_glyph_lookup: table loads, directed and random lookups, checked beat by beat.
module cmap_glyph_lookup_tb;
  import cgl_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int WORD_PREFIX = 300;
  localparam logic [1:0] REG_SPARE = 2'd3;

  class glyph_map_board;
    int unsigned group_cnt, segment_cnt, word_cnt;
    logic [31:0] grp_first [256];
    logic [31:0] grp_last [256];
    logic [31:0] grp_glyph [256];
    logic [15:0] seg_first [256];
    logic [15:0] seg_last [256];
    logic [15:0] seg_delta [256];
    logic [15:0] seg_offset [256];
    logic [15:0] words [4096];
    logic [31:0] want_glyph [$];
    logic [1:0] want_source [$];
    int errors;
    int lookups;
    int by_source [4];

    function void set_reg(logic [1:0] idx, logic [12:0] data);
      case (idx)
        REG_GROUPS: group_cnt = data[8:0];
        REG_SEGMENTS: segment_cnt = data[8:0];
        REG_WORDS: word_cnt = data;
        default: ;
      endcase
    endfunction

    function void map_code(input logic [20:0] code, output logic [31:0] g, output logic [1:0] s);
      int n;
      int unsigned ix;
      g = '0;
      s = SRC_NONE;
      n = (group_cnt > 256) ? 256 : group_cnt;
      for (int i = 0; i < n; i++) begin
        if ({11'b0, code} >= grp_first[i] && {11'b0, code} <= grp_last[i]) begin
          g = grp_glyph[i] + ({11'b0, code} - grp_first[i]);
          s = SRC_GROUP;
          return;
        end
      end
      if (code > BMP_LAST) return;
      n = (segment_cnt > 256) ? 256 : segment_cnt;
      for (int i = 0; i < n; i++) begin
        if (code[15:0] > seg_last[i]) continue;
        if (code[15:0] < seg_first[i]) return;
        if (seg_offset[i] == 0) begin
          g = {16'b0, 16'(code[15:0] + seg_delta[i])};
          s = SRC_DELTA;
          return;
        end
        ix = i + (seg_offset[i] >> 1) + (code[15:0] - seg_first[i]);
        if (ix >= ((word_cnt > 4096) ? 4096 : word_cnt)) return;
        if (words[ix] == 0) return;
        g = {16'b0, 16'(words[ix] + seg_delta[i])};
        s = SRC_ARRAY;
        return;
      end
    endfunction

    function void note_beat(logic [183:0] d);
      logic [11:0] idx;
      logic [31:0] g;
      logic [1:0] s;
      idx = d[13:2];
      case (d[1:0])
        OP_LOOKUP: begin
          map_code(d[34:14], g, s);
          want_glyph.push_back(g);
          want_source.push_back(s);
          lookups++;
        end
        OP_GROUP: if (idx < 256) begin
          grp_first[idx] = d[66:35];
          grp_last[idx] = d[98:67];
          grp_glyph[idx] = d[130:99];
        end
        OP_SEGMENT: if (idx < 256) begin
          seg_first[idx] = d[50:35];
          seg_last[idx] = d[82:67];
          seg_delta[idx] = d[146:131];
          seg_offset[idx] = d[162:147];
        end
        default: words[idx] = d[178:163];
      endcase
    endfunction

    function void check_beat(logic [39:0] d);
      logic [31:0] g;
      logic [1:0] s;
      if (want_glyph.size() == 0) begin
        $display("%0t: unexpected result glyph %h source %0d", $time, d[31:0], d[33:32]);
        errors++;
        return;
      end
      g = want_glyph.pop_front();
      s = want_source.pop_front();
      by_source[s]++;
      if (d[31:0] !== g) begin
        $display("%0t: glyph_id expected %h actual %h", $time, g, d[31:0]);
        errors++;
      end
      if (d[33:32] !== s) begin
        $display("%0t: map_source expected %0d actual %0d", $time, s, d[33:32]);
        errors++;
      end
      if (d[39:34] !== '0) begin
        $display("%0t: pad expected 0 actual %h", $time, d[39:34]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [183:0] s_axis_tdata;
  logic [39:0] m_axis_tdata;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;

  glyph_map_board board = new();
  bit calm = 0;
  bit want_hold = 0;
  int hold_left = 0;
  int cycles = 0;

  cmap_glyph_lookup DUT (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** cmap_glyph_lookup: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (want_hold) begin
      want_hold = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_beat(m_axis_tdata);

  function automatic logic [183:0] pack(logic [1:0] op, logic [11:0] idx, logic [20:0] code,
                                        logic [31:0] st, logic [31:0] en, logic [31:0] base,
                                        logic [15:0] dl, logic [15:0] ro, logic [15:0] w);
    return {5'b0, w, ro, dl, base, en, st, code, idx, op};
  endfunction

  function automatic logic [183:0] make_group(int i);
    logic [31:0] first, last;
    first = 32'h10000 + i * 32'h1000 + $urandom_range(0, 255);
    last = first + $urandom_range(0, 2047);
    if (i == 5) begin
      first = 32'h41;
      last = 32'h5A;
    end
    if (i == 0) return pack(OP_GROUP, 0, $urandom, 32'h1F0000, 32'hFFFFFFFF, 32'hFFFFFFF0,
                            $urandom, $urandom, $urandom);
    return pack(OP_GROUP, i, $urandom, first, last, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic logic [183:0] make_segment(int i);
    logic [31:0] first, last;
    logic [15:0] off;
    first = {$urandom_range(0, 65535), 16'(i * 256 + $urandom_range(0, 63))};
    last = {$urandom_range(0, 65535), 16'(i * 256 + 128 + $urandom_range(0, 127))};
    if (i == 255) last[15:0] = 16'hFFFF;
    off = (i % 3 == 0) ? 16'd0 : 16'($urandom_range(1, 300));
    return pack(OP_SEGMENT, i, $urandom, first, last, $urandom, $urandom, off, $urandom);
  endfunction

  function automatic logic [20:0] pick_code();
    int r, i;
    r = $urandom_range(0, 99);
    if (r < 40 && board.group_cnt > 0) begin
      i = $urandom_range(0, (board.group_cnt > 256 ? 256 : board.group_cnt) - 1);
      return 21'(board.grp_first[i] + $urandom_range(0, 40) - 3);
    end
    if (r < 75) return 21'($urandom_range(0, 65535));
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 21'h0;
        1: return 21'h00FFFF;
        2: return 21'h010000;
        default: return 21'h1FFFFF;
      endcase
    end
    return 21'($urandom);
  endfunction

  task automatic offer_beat(logic [183:0] d);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_beat(d);
    gap = calm ? 0 : (($urandom_range(0, 99) < 32) ? $urandom_range(1, 4) : 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.want_glyph.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, data);
  endtask

  task automatic configure(logic [12:0] g, logic [12:0] s, logic [12:0] w);
    drain();
    write_reg(REG_GROUPS, g);
    write_reg(REG_SEGMENTS, s);
    write_reg(REG_WORDS, w);
  endtask

  task automatic random_batch(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) offer_beat(pack(OP_LOOKUP, $urandom, pick_code(), $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom));
      else if (r < 65) offer_beat(make_group($urandom_range(0, 255)));
      else if (r < 75) offer_beat(make_segment($urandom_range(0, 255)));
      else if (r < 85) offer_beat(pack(OP_WORD, $urandom_range(0, WORD_PREFIX - 1), $urandom,
                                       $urandom, $urandom, $urandom, $urandom, $urandom,
                                       ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom)));
      else offer_beat(pack($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    logic [12:0] g, s, w;
    logic [20:0] probes [14];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GROUPS;
    cfg_data = '0;
    probes = '{21'h0, 21'h41, 21'h5A, 21'h5B, 21'hFFFF, 21'h10000, 21'h1FFFFF, 21'h1F0000,
               21'h1F0010, 21'hFE00, 21'hFE05, 21'h100, 21'h200, 21'h180};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load every group and segment, and a prefix of the word store
    for (int i = 0; i < 256; i++) offer_beat(make_group(i));
    for (int i = 0; i < 256; i++) offer_beat(make_segment(i));
    for (int i = 0; i < WORD_PREFIX; i++)
      offer_beat(pack(OP_WORD, i, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom)));

    configure(8, 256, WORD_PREFIX);
    write_reg(REG_SPARE, 13'h1FFF);
    offer_beat(pack(OP_GROUP, 12'hFFF, 0, 32'h0, 32'hFFFFFFFF, 32'h1, 0, 0, 0));
    offer_beat(pack(OP_SEGMENT, 12'd300, 0, 32'h0, 32'hFFFF, 0, 16'h1, 0, 0));
    offer_beat(pack(OP_WORD, 12'hFFF, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    offer_beat(pack(OP_SEGMENT, 12'd254, 0, 32'hFE00, 32'hFEFF, 0, 16'h0200, 16'h0, 0));
    offer_beat(pack(OP_SEGMENT, 12'd1, 0, 32'h100, 32'h1FF, 0, 16'h5, 16'h7, 0));
    offer_beat(pack(OP_SEGMENT, 12'd2, 0, 32'h200, 32'h2FF, 0, 16'h8000, 16'hFFFE, 0));
    foreach (probes[j]) begin
      offer_beat(pack(OP_LOOKUP, 0, probes[j], 0, 0, 0, 0, 0, 0));
    end
    offer_beat(pack(OP_WORD, 12'd4, 0, 0, 0, 0, 0, 0, 16'h0));
    offer_beat(pack(OP_LOOKUP, 0, 21'h100, 0, 0, 0, 0, 0, 0));
    offer_beat(pack(OP_WORD, 12'd4, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    offer_beat(pack(OP_LOOKUP, 0, 21'h100, 0, 0, 0, 0, 0, 0));

    for (int p = 0; p < 14; p++) begin
      case (p)
        0: begin g = 256; s = 256; w = WORD_PREFIX; end
        1: begin g = 0; s = 0; w = 0; end
        2: begin g = 13'h1FFF; s = 0; w = 13'h1FFF; end
        3: begin g = 0; s = 13'h1FFF; w = 0; end
        4: begin g = 1; s = 0; w = 4096; end
        default: begin
          g = $urandom_range(0, 20);
          s = $urandom_range(0, 256);
          w = $urandom_range(0, WORD_PREFIX);
        end
      endcase
      configure(g, s, w);
      calm = (p == 5);
      if (p == 7) want_hold = 1;
      if (p == 9) begin
        random_batch(40);
        drain();
      end
      random_batch((p == 0 || p == 2 || p == 3) ? 10 : 20);
    end

    drain();
    repeat (50) @(posedge clk);
    if (board.want_glyph.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.want_glyph.size());
      board.errors++;
    end
    $display("Covered %0d lookups: %0d unmapped, %0d by group, %0d by delta, %0d via array.",
             board.lookups, board.by_source[0], board.by_source[1], board.by_source[2],
             board.by_source[3]);
    $display("Table counts swept from zero to saturation, with stalls and long back-pressure.");
    if (board.errors == 0) begin
      $display("** cmap_glyph_lookup: PASSED **");
    end else begin
      $display("** cmap_glyph_lookup: FAILED **");
    end
    $finish;
  end
endmodule
